[hw/rtl/nal_ebr_pkg.sv]
`timescale 1ns / 1ps

package nal_ebr_pkg;

  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [7:0] EmuByte   = 8'h03;
  localparam logic [1:0] ZeroRunMax = 2'd3;
  localparam logic [1:0] ZeroRunStart = 2'd2;

  // One queue entry describes the words caused by one input word: an optional
  // held byte followed by a number of zero bytes.
  typedef struct packed {
    logic       held_emit;
    logic [7:0] held_value;
    logic [1:0] zeros;
    logic       first;
    logic       last;
    logic       err;
  } entry_t;

endpackage

[hw/rtl/nal_emulation_byte_removal.sv]
`timescale 1ns / 1ps

// Annex B start code and emulation prevention byte removal.
// Input channel: a word (in_byte_i, flush_i) is taken at a rising edge with
// push high and full low. A word with flush_i set ends the stream and closes
// the open unit; its byte is ignored.
// Result channel: while empty is low the oldest payload byte and its first,
// last and error marks are on the result ports; pop takes it.
// The block takes one input word every cycle while the queue has room. The
// newest payload byte is held inside until the next non-zero byte, start code
// or flush shows whether it is last, so a byte leaves only after a later
// input word. From that word, the result passes through the queue and the
// output register to the ports.
// One input word can cause up to four result words, which leave one per cycle
// through the output register while not stalled; the queue between the parser
// and the output absorbs such bursts and raises full when no entry is free.
// When the receiver stalls, the current result holds, the queue fills and
// full stops the input. Reset clears the queue and returns the parser to the
// state before the first start code.
module nal_emulation_byte_removal #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       flush_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] rbsp_out_o,
  output logic       first_of_unit_o,
  output logic       last_of_unit_o,
  output logic       zero_run_error_o
);
  import nal_ebr_pkg::*;

  logic   accept;
  logic   enq;
  entry_t enq_entry;
  entry_t head;
  logic   head_empty;
  logic   head_pop;

  assign accept = push && !full;

  nal_ebr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .flush_i   (flush_i),
    .enq_o     (enq),
    .entry_o   (enq_entry)
  );

  nal_ebr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (enq),
    .wr_data_i (enq_entry),
    .full_o    (full),
    .rd_i      (head_pop),
    .rd_data_o (head),
    .empty_o   (head_empty)
  );

  nal_ebr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_empty_i     (head_empty),
    .head_pop_o       (head_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .rbsp_out_o       (rbsp_out_o),
    .first_of_unit_o  (first_of_unit_o),
    .last_of_unit_o   (last_of_unit_o),
    .zero_run_error_o (zero_run_error_o)
  );

endmodule

[hw/rtl/nal_ebr_front.sv]
`timescale 1ns / 1ps

module nal_ebr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                flush_i,
  output logic                enq_o,
  output nal_ebr_pkg::entry_t entry_o
);
  import nal_ebr_pkg::*;

  logic       inside_q, inside_d;
  logic       held_valid_q, held_valid_d;
  logic [7:0] held_value_q, held_value_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic       first_pending_q, first_pending_d;
  logic       emu;

  assign emu = (in_byte_i == EmuByte) && (zero_run_q >= ZeroRunStart);

  always_comb begin
    inside_d        = inside_q;
    held_valid_d    = held_valid_q;
    held_value_d    = held_value_q;
    zero_run_d      = zero_run_q;
    first_pending_d = first_pending_q;
    enq_o           = 1'b0;
    entry_o         = '0;
    if (accept_i) begin
      if (flush_i || ((in_byte_i == StartByte) && (zero_run_q >= ZeroRunStart))) begin
        entry_o.held_emit  = held_valid_q;
        entry_o.held_value = held_value_q;
        entry_o.first      = first_pending_q;
        entry_o.last       = 1'b1;
        enq_o              = held_valid_q;
        held_valid_d       = 1'b0;
        held_value_d       = ZeroByte;
        zero_run_d         = '0;
        inside_d           = !flush_i;
        first_pending_d    = !flush_i;
      end else if (in_byte_i == ZeroByte) begin
        if (zero_run_q != ZeroRunMax) begin
          zero_run_d = zero_run_q + 2'd1;
        end
      end else begin
        zero_run_d = '0;
        if (inside_q) begin
          entry_o.held_emit  = held_valid_q;
          entry_o.held_value = held_value_q;
          entry_o.zeros      = emu ? (zero_run_q - 2'd1) : zero_run_q;
          entry_o.first      = first_pending_q;
          entry_o.err        = (zero_run_q == ZeroRunMax);
          enq_o              = held_valid_q || (entry_o.zeros != 2'd0);
          if (enq_o) begin
            first_pending_d = 1'b0;
          end
          held_value_d = emu ? ZeroByte : in_byte_i;
          held_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q        <= 1'b0;
      held_valid_q    <= 1'b0;
      held_value_q    <= ZeroByte;
      zero_run_q      <= '0;
      first_pending_q <= 1'b0;
    end else begin
      inside_q        <= inside_d;
      held_valid_q    <= held_valid_d;
      held_value_q    <= held_value_d;
      zero_run_q      <= zero_run_d;
      first_pending_q <= first_pending_d;
    end
  end

endmodule

[hw/rtl/nal_ebr_queue.sv]
`timescale 1ns / 1ps

module nal_ebr_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  nal_ebr_pkg::entry_t wr_data_i,
  output logic                full_o,
  input  logic                rd_i,
  output nal_ebr_pkg::entry_t rd_data_o,
  output logic                empty_o
);
  import nal_ebr_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/nal_ebr_back.sv]
`timescale 1ns / 1ps

module nal_ebr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nal_ebr_pkg::entry_t head_i,
  input  logic                head_empty_i,
  output logic                head_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          rbsp_out_o,
  output logic                first_of_unit_o,
  output logic                last_of_unit_o,
  output logic                zero_run_error_o
);
  import nal_ebr_pkg::*;

  logic [1:0] idx_q;
  logic [2:0] total;
  logic       last_word;
  logic       adv;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_first_q, out_last_q, out_err_q;

  assign total     = {2'b00, head_i.held_emit} + {1'b0, head_i.zeros};
  assign last_word = (({1'b0, idx_q} + 3'd1) == total);
  assign adv       = !head_empty_i && (!out_valid_q || pop_i);
  assign head_pop_o = adv && last_word;

  assign empty_o          = !out_valid_q;
  assign rbsp_out_o       = out_byte_q;
  assign first_of_unit_o  = out_first_q;
  assign last_of_unit_o   = out_last_q;
  assign zero_run_error_o = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_word ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q  <= (head_i.held_emit && (idx_q == 2'd0)) ? head_i.held_value : ZeroByte;
      out_first_q <= head_i.first && (idx_q == 2'd0);
      out_last_q  <= head_i.last;
      out_err_q   <= head_i.err;
    end
  end

endmodule

[hw/rtl/nal_ebr_checker.sv]
`timescale 1ns / 1ps

module nal_ebr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte_i,
  input logic       flush_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] rbsp_out_o,
  input logic       first_of_unit_o,
  input logic       last_of_unit_o,
  input logic       zero_run_error_o
);

  // Reset leaves no result waiting and room for input.
  assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("reset does not clear the channels");

  // A closing word never carries the zero run flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(last_of_unit_o && zero_run_error_o))
    else $error("last word flagged with zero run error");

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before pop");

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(rbsp_out_o) && $stable(first_of_unit_o) &&
                          $stable(last_of_unit_o) && $stable(zero_run_error_o)))
    else $error("result changed while stalled");

endmodule

bind nal_emulation_byte_removal nal_ebr_checker u_checker (.*);
